// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// A condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

// ===== rtl/rbi_pkg.sv =====
// Shared types, constants and helper functions of the rigid body integrator.
// No dependencies; used by rbi_iter and the top level of the block.
package rbi_pkg;

    localparam int F            = 16;
    localparam int BODY_COUNT   = 64;
    localparam int BODY_W       = $clog2(BODY_COUNT);
    localparam int SLOT_W       = 4;
    localparam int RAM_DEPTH    = BODY_COUNT * (2 ** SLOT_W);
    localparam int RAM_AW       = BODY_W + SLOT_W;

    localparam logic signed [63:0] ONE    = 64'sd1 <<< F;
    localparam logic [47:0]        ONE_SQ = 48'd1 << (2 * F);
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // Word slots of one body in the state memory.
    localparam logic [3:0] W_P   = 4'd0;
    localparam logic [3:0] W_V   = 4'd3;
    localparam logic [3:0] W_S   = 4'd6;
    localparam logic [3:0] W_Q   = 4'd9;
    localparam logic [3:0] W_CNT = 4'd13;

    localparam logic [1:0] ACT_STEP  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [2:0] PART_POS    = 3'd0;
    localparam logic [2:0] PART_VEL    = 3'd1;
    localparam logic [2:0] PART_SPIN   = 3'd2;
    localparam logic [2:0] PART_ORIENT = 3'd3;
    localparam logic [2:0] PART_STATIC = 3'd4;

    localparam logic [2:0] CFG_GX = 3'd0;
    localparam logic [2:0] CFG_GY = 3'd1;
    localparam logic [2:0] CFG_GZ = 3'd2;
    localparam logic [2:0] CFG_LD = 3'd3;
    localparam logic [2:0] CFG_AD = 3'd4;

    typedef enum logic {ITER_DIV, ITER_SQRT} t_iter_op;

    typedef struct packed {
        logic     start;
        t_iter_op op;
    } t_iter_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_sts;

    // One term of the Hamilton product spin * orientation.
    typedef struct packed {
        logic [1:0] s_idx;
        logic [1:0] q_idx;
        logic       neg;
        logic       last;
        logic [1:0] c;
    } t_dq_term;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > S32_MAX) r = 32'sh7fffffff;
        else if (x < S32_MIN) r = 32'sh80000000;
        else r = x[31:0];
        return r;
    endfunction

    function automatic t_dq_term dq_term(input logic [3:0] k);
        t_dq_term t;
        unique case (k)
            4'd0:    t = '{2'd0, 2'd3, 1'b0, 1'b0, 2'd0};
            4'd1:    t = '{2'd1, 2'd2, 1'b0, 1'b0, 2'd0};
            4'd2:    t = '{2'd2, 2'd1, 1'b1, 1'b1, 2'd0};
            4'd3:    t = '{2'd0, 2'd2, 1'b1, 1'b0, 2'd1};
            4'd4:    t = '{2'd1, 2'd3, 1'b0, 1'b0, 2'd1};
            4'd5:    t = '{2'd2, 2'd0, 1'b0, 1'b1, 2'd1};
            4'd6:    t = '{2'd0, 2'd1, 1'b0, 1'b0, 2'd2};
            4'd7:    t = '{2'd1, 2'd0, 1'b1, 1'b0, 2'd2};
            4'd8:    t = '{2'd2, 2'd3, 1'b0, 1'b1, 2'd2};
            4'd9:    t = '{2'd0, 2'd0, 1'b1, 1'b0, 2'd3};
            4'd10:   t = '{2'd1, 2'd1, 1'b1, 1'b0, 2'd3};
            4'd11:   t = '{2'd2, 2'd2, 1'b1, 1'b1, 2'd3};
            default: t = '{2'd0, 2'd0, 1'b0, 1'b0, 2'd0};
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/rbi_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module rbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== rtl/rbi_iter.sv =====
// Bit-serial divide and square root unit, one result bit per cycle.
// Depends on rbi_pkg.
module rbi_iter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbi_pkg::t_iter_req i_req,
    input  logic [63:0]       i_a,
    input  logic [31:0]       i_b,
    output rbi_pkg::t_iter_sts o_sts,
    output logic [47:0]       o_result
);
    import rbi_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_iter_op    r_op;
    logic [5:0]  r_cnt;
    logic [63:0] r_quo;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [31:0] r_div;

    logic [32:0] w_dt;
    logic        w_dge;
    logic [34:0] w_st;
    logic [34:0] w_trial;
    logic        w_sge;

    always_comb begin
        w_dt    = {r_rem[31:0], r_quo[47]};
        w_dge   = w_dt >= {1'b0, r_div};
        w_st    = {r_rem[32:0], r_quo[63:62]};
        w_trial = {1'b0, r_root, 2'b01};
        w_sge   = w_st >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= (i_req.op == ITER_DIV) ? 6'd47 : 6'd31;
                r_quo  <= i_a;
                r_rem  <= '0;
                r_root <= '0;
                r_div  <= i_b;
            end else if (r_busy) begin
                if (r_op == ITER_DIV) begin
                    r_rem <= w_dge ? 34'(w_dt - {1'b0, r_div}) : 34'(w_dt);
                    r_quo <= {r_quo[62:0], w_dge};
                end else begin
                    r_rem  <= w_sge ? 34'(w_st - w_trial) : w_st[33:0];
                    r_root <= {r_root[30:0], w_sge};
                    r_quo  <= {r_quo[61:0], 2'b00};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_result   = (r_op == ITER_DIV) ? r_quo[47:0] : {16'd0, r_root};

endmodule

// ===== rtl/rigid_body_integrator.sv =====
// Top level of the rigid body integrator: sequencer, multiplier, state memory.
// Depends on rbi_pkg, rbi_ram, rbi_iter and assert_macros.svh.
//
// Channel   Direction  Carries
// s_*       in         one command word: step, write or read of one body
// m_*       out        one read result word
// i_cfg_*   in         gravity and damping register writes
//
// A step loads the body from the state memory, runs two reciprocal divides,
// a square root and four normalizing divides in the bit-serial unit, forms
// its products on the shared 32x32 multiplier and stores the body back; a
// body without spin skips the square root and the divides after it, and a
// zero length skips the normalizing divides. Reset is synchronous and clears
// the sequencer, the result valid, the static flags and the gravity and
// damping registers; the state memory holds garbage until written.
// A new command word is taken whenever the sequencer is idle, also while an
// earlier result still waits; a second result waits for the first to drain.
module rigid_body_integrator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Command word.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: body[5:0], val_x[37:6], val_y[69:38], val_z[101:70],
    //        val_w[133:102], delta[164:134], zero fill [167:165]
    input  logic [167:0] s_tdata,
    // tuser: action[1:0], part[4:2]
    input  logic [4:0]   s_tuser,
    // Result word.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: out_body[5:0], out_x[37:6], out_y[69:38], out_z[101:70],
    //        out_w[133:102], zero fill [135:134]
    output logic [135:0] m_tdata,
    // tuser: out_part[2:0]
    output logic [2:0]   m_tuser,
    // Register writes.
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata
);
    import rbi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WR, ST_LOAD, ST_DEN, ST_DWAIT, ST_VEL, ST_DQ, ST_NRM,
        ST_SQRT, ST_SWAIT, ST_QDIV, ST_QWAIT, ST_STORE, ST_OUT
    } t_state;

    // Input field split.
    logic [1:0]         w_action;
    logic [2:0]         w_part;
    logic [5:0]         w_body;
    logic signed [31:0] w_val [4];
    logic [30:0]        w_delta;
    logic               w_body_ok;
    logic               w_accept;

    assign w_action = s_tuser[1:0];
    assign w_part   = s_tuser[4:2];
    assign w_body   = s_tdata[5:0];
    assign w_val[0] = s_tdata[37:6];
    assign w_val[1] = s_tdata[69:38];
    assign w_val[2] = s_tdata[101:70];
    assign w_val[3] = s_tdata[133:102];
    assign w_delta  = s_tdata[164:134];
    assign w_body_ok = 32'(w_body) < BODY_COUNT;

    // Control and configuration.
    t_state             r_state;
    logic [3:0]         r_k;
    logic               r_ph;
    logic               r_step;
    logic               r_static [BODY_COUNT];
    logic signed [31:0] r_grav [3];
    logic [30:0]        r_ld;
    logic [30:0]        r_ad;

    // Command and working registers.
    logic [BODY_W-1:0]  r_body;
    logic [5:0]         r_body_echo;
    logic [2:0]         r_part;
    logic signed [31:0] r_val [4];
    logic [30:0]        r_delta;
    logic signed [31:0] r_p [3];
    logic signed [31:0] r_v [3];
    logic signed [31:0] r_s [3];
    logic signed [31:0] r_q [4];
    logic signed [31:0] r_fl;
    logic signed [31:0] r_fa;
    logic signed [31:0] r_dq [4];
    logic signed [31:0] r_n [4];
    logic signed [63:0] r_acc;
    logic [64:0]        r_sum;
    logic [31:0]        r_len;
    logic signed [31:0] r_res [4];
    logic signed [63:0] r_prod;

    // Output register.
    logic               r_mvalid;
    logic [135:0]       r_mdata;
    logic [2:0]         r_mpart;

    // Memory and iterative unit.
    logic               w_ram_we;
    logic [RAM_AW-1:0]  w_ram_addr;
    logic [31:0]        w_ram_wdata;
    logic [31:0]        w_ram_rdata;
    t_iter_req          w_req;
    t_iter_sts          w_sts;
    logic [63:0]        w_ia;
    logic [31:0]        w_ib;
    logic [47:0]        w_ires;

    // Multiplier operand selection and helpers.
    logic signed [31:0] w_ma;
    logic signed [31:0] w_mb;
    logic [1:0]         w_j;
    t_dq_term           w_term;
    logic signed [63:0] w_fm;
    logic signed [63:0] w_den;
    logic [3:0]         w_base;
    logic [31:0]        w_nabs;
    logic signed [63:0] w_qsig;
    logic signed [31:0] w_delta_s;

    assign w_delta_s = $signed({1'b0, r_delta});
    assign w_fm      = r_prod >>> F;
    assign w_term    = dq_term(r_k);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        w_j  = '0;
        unique case (r_state)
            ST_DEN: begin
                w_ma = r_k[0] ? $signed({1'b0, r_ad}) : $signed({1'b0, r_ld});
                w_mb = w_delta_s;
            end
            ST_VEL: begin
                if (r_k < 4'd3) begin
                    w_j  = r_k[1:0];
                    w_ma = r_grav[w_j];
                    w_mb = w_delta_s;
                end else if (r_k < 4'd6) begin
                    w_j  = 2'(r_k - 4'd3);
                    w_ma = r_v[w_j];
                    w_mb = r_fl;
                end else if (r_k < 4'd9) begin
                    w_j  = 2'(r_k - 4'd6);
                    w_ma = r_s[w_j];
                    w_mb = r_fa;
                end else begin
                    w_j  = 2'(r_k - 4'd9);
                    w_ma = r_v[w_j];
                    w_mb = w_delta_s;
                end
            end
            ST_DQ: begin
                w_ma = r_s[w_term.s_idx];
                w_mb = r_q[w_term.q_idx];
            end
            ST_NRM: begin
                w_j = r_k[1:0];
                if (r_k < 4'd4) begin
                    w_ma = r_dq[w_j];
                    w_mb = w_delta_s;
                end else begin
                    w_ma = r_n[w_j];
                    w_mb = r_n[w_j];
                end
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_ma * w_mb);
    end

    // The denominator of the damping factor, clamped to the largest word.
    always_comb begin
        w_den = ONE + w_fm;
        if (w_den > S32_MAX) begin
            w_den = S32_MAX;
        end
    end

    always_comb begin
        unique case (r_part)
            PART_POS:  w_base = W_P;
            PART_VEL:  w_base = W_V;
            PART_SPIN: w_base = W_S;
            default:   w_base = W_Q;
        endcase
    end

    assign w_nabs = r_n[r_k[1:0]][31] ? 32'(-r_n[r_k[1:0]]) : 32'(r_n[r_k[1:0]]);
    assign w_qsig = r_n[r_k[1:0]][31] ? -$signed({16'd0, w_ires})
                                      : $signed({16'd0, w_ires});

    // Memory port: writes of commands and the store sweep, reads of the load sweep.
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_addr  = {r_body, r_k};
        w_ram_wdata = '0;
        if (r_state == ST_WR) begin
            w_ram_we    = 1'b1;
            w_ram_addr  = {r_body, 4'(w_base + r_k)};
            w_ram_wdata = r_val[r_k[1:0]];
        end else if (r_state == ST_STORE) begin
            w_ram_we = 1'b1;
            if (r_k < W_V)      w_ram_wdata = r_p[2'(r_k)];
            else if (r_k < W_S) w_ram_wdata = r_v[2'(r_k - W_V)];
            else if (r_k < W_Q) w_ram_wdata = r_s[2'(r_k - W_S)];
            else                w_ram_wdata = r_q[2'(r_k - W_Q)];
        end
    end

    // Requests to the divide and square root unit.
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = ITER_DIV;
        w_ia        = 64'(ONE_SQ);
        w_ib        = 32'(w_den);
        unique case (r_state)
            ST_DEN:  w_req.start = r_ph;
            ST_SQRT: begin
                w_req.start = 1'b1;
                w_req.op    = ITER_SQRT;
                w_ia        = r_sum[64] ? '1 : r_sum[63:0];
            end
            ST_QDIV: begin
                w_req.start = 1'b1;
                w_ia        = 64'({w_nabs, 16'd0}) << (F - 16);
                w_ib        = r_len;
            end
            default: w_req.start = 1'b0;
        endcase
    end

    rbi_ram #(
        .WIDTH(32),
        .DEPTH(RAM_DEPTH)
    ) u_state_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_addr (w_ram_addr),
        .i_wdata(w_ram_wdata),
        .o_rdata(w_ram_rdata)
    );

    rbi_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_ia),
        .i_b     (w_ib),
        .o_sts   (w_sts),
        .o_result(w_ires)
    );

    assign s_tready = (r_state == ST_IDLE);
    assign w_accept = s_tvalid && s_tready;

    // Sequencer: state, working registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mvalid <= 1'b0;
            r_ph     <= 1'b0;
            r_k      <= '0;
            r_step   <= 1'b0;
            r_ld     <= '0;
            r_ad     <= '0;
            for (int i = 0; i < 3; i++) r_grav[i] <= '0;
            for (int i = 0; i < BODY_COUNT; i++) r_static[i] <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GX:  r_grav[0] <= i_cfg_wdata;
                    CFG_GY:  r_grav[1] <= i_cfg_wdata;
                    CFG_GZ:  r_grav[2] <= i_cfg_wdata;
                    CFG_LD:  r_ld <= i_cfg_wdata[30:0];
                    CFG_AD:  r_ad <= i_cfg_wdata[30:0];
                    default: r_ld <= r_ld;
                endcase
            end

            if (r_mvalid && m_tready) begin
                r_mvalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_k  <= '0;
                    r_ph <= 1'b0;
                    if (w_accept) begin
                        r_body      <= w_body[BODY_W-1:0];
                        r_body_echo <= w_body;
                        r_part      <= w_part;
                        r_delta     <= w_delta;
                        for (int i = 0; i < 4; i++) r_val[i] <= w_val[i];
                        for (int i = 0; i < 4; i++) r_res[i] <= '0;
                        priority if (w_action == ACT_STEP) begin
                            if (w_body_ok && !r_static[w_body[BODY_W-1:0]]) begin
                                r_step  <= 1'b1;
                                r_state <= ST_LOAD;
                            end
                        end else if (w_action == ACT_WRITE) begin
                            if (w_body_ok && w_part < PART_STATIC) begin
                                r_state <= ST_WR;
                            end else if (w_body_ok && w_part == PART_STATIC) begin
                                r_static[w_body[BODY_W-1:0]] <= w_val[0][0];
                            end
                        end else if (w_action == ACT_READ) begin
                            if (w_body_ok && w_part < PART_STATIC) begin
                                r_step  <= 1'b0;
                                r_state <= ST_LOAD;
                            end else begin
                                if (w_body_ok && w_part == PART_STATIC) begin
                                    r_res[0] <= 32'(r_static[w_body[BODY_W-1:0]]);
                                end
                                r_state <= ST_OUT;
                            end
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end

                ST_WR: begin
                    r_k <= r_k + 4'd1;
                    if (r_k == ((r_part == PART_ORIENT) ? 4'd3 : 4'd2)) begin
                        r_state <= ST_IDLE;
                    end
                end

                ST_LOAD: begin
                    // Read data arrives in the cycle after its address.
                    if (r_k != 4'd0) begin
                        if (r_k <= W_V)      r_p[2'(r_k - 4'd1)]       <= w_ram_rdata;
                        else if (r_k <= W_S) r_v[2'(r_k - 4'd1 - W_V)] <= w_ram_rdata;
                        else if (r_k <= W_Q) r_s[2'(r_k - 4'd1 - W_S)] <= w_ram_rdata;
                        else                 r_q[2'(r_k - 4'd1 - W_Q)] <= w_ram_rdata;
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == W_CNT) begin
                        r_k <= '0;
                        r_state <= r_step ? ST_DEN : ST_OUT;
                    end
                end

                ST_DEN: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_state <= ST_DWAIT;
                    end
                end

                ST_DWAIT: begin
                    if (w_sts.done) begin
                        if (r_k == 4'd0) begin
                            r_fl    <= 32'(w_ires);
                            r_k     <= 4'd1;
                            r_state <= ST_DEN;
                        end else begin
                            r_fa    <= 32'(w_ires);
                            r_k     <= '0;
                            r_state <= ST_VEL;
                        end
                    end
                end

                ST_VEL: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (r_k < 4'd3)      r_v[w_j] <= sat32(64'(r_v[w_j]) + w_fm);
                        else if (r_k < 4'd6) r_v[w_j] <= sat32(w_fm);
                        else if (r_k < 4'd9) r_s[w_j] <= sat32(w_fm);
                        else                 r_p[w_j] <= sat32(64'(r_p[w_j]) + w_fm);
                        r_k <= r_k + 4'd1;
                        if (r_k == 4'd11) begin
                            r_k   <= '0;
                            r_acc <= '0;
                            // A body without spin keeps its orientation.
                            if (r_s[0] == 0 && r_s[1] == 0 && r_s[2] == 0) begin
                                r_state <= ST_STORE;
                            end else begin
                                r_state <= ST_DQ;
                            end
                        end
                    end
                end

                ST_DQ: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (w_term.last) begin
                            r_dq[w_term.c] <= sat32(r_acc + (w_term.neg ? -w_fm : w_fm));
                            r_acc <= '0;
                        end else begin
                            r_acc <= r_acc + (w_term.neg ? -w_fm : w_fm);
                        end
                        r_k <= r_k + 4'd1;
                        if (r_k == 4'd11) begin
                            r_k     <= '0;
                            r_sum   <= '0;
                            r_state <= ST_NRM;
                        end
                    end
                end

                ST_NRM: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (r_k < 4'd4) begin
                            r_n[w_j] <= sat32(64'(r_q[w_j]) + (r_prod >>> (F + 1)));
                        end else begin
                            r_sum <= r_sum + 65'(r_prod);
                        end
                        r_k <= r_k + 4'd1;
                        if (r_k == 4'd7) begin
                            r_k     <= '0;
                            r_state <= ST_SQRT;
                        end
                    end
                end

                ST_SQRT: r_state <= ST_SWAIT;

                ST_SWAIT: begin
                    if (w_sts.done) begin
                        r_len <= w_ires[31:0];
                        // A zero length leaves the orientation as it was.
                        r_state <= (w_ires[31:0] == 32'd0) ? ST_STORE : ST_QDIV;
                    end
                end

                ST_QDIV: r_state <= ST_QWAIT;

                ST_QWAIT: begin
                    if (w_sts.done) begin
                        r_q[r_k[1:0]] <= sat32(w_qsig);
                        r_k <= r_k + 4'd1;
                        if (r_k == 4'd3) begin
                            r_k     <= '0;
                            r_state <= ST_STORE;
                        end else begin
                            r_state <= ST_QDIV;
                        end
                    end
                end

                ST_STORE: begin
                    r_k <= r_k + 4'd1;
                    if (r_k == W_CNT - 4'd1) begin
                        r_state <= ST_IDLE;
                    end
                end

                ST_OUT: begin
                    if (!r_mvalid || m_tready) begin
                        r_mvalid <= 1'b1;
                        r_mpart  <= r_part;
                        r_mdata[5:0]     <= r_body_echo;
                        r_mdata[135:134] <= '0;
                        if (r_step) begin
                            r_mdata[133:6] <= {r_res[3], r_res[2], r_res[1], r_res[0]};
                        end else begin
                            unique case (r_part)
                                PART_POS: r_mdata[133:6] <= {32'd0, r_p[2], r_p[1], r_p[0]};
                                PART_VEL: r_mdata[133:6] <= {32'd0, r_v[2], r_v[1], r_v[0]};
                                PART_SPIN: r_mdata[133:6] <= {32'd0, r_s[2], r_s[1], r_s[0]};
                                PART_ORIENT:
                                    r_mdata[133:6] <= {r_q[3], r_q[2], r_q[1], r_q[0]};
                                default:
                                    r_mdata[133:6] <= {r_res[3], r_res[2], r_res[1], r_res[0]};
                            endcase
                        end
                        r_state <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase

            // Reads that need no memory come straight from idle and set r_step
            // so that the output takes the prepared values.
            if (r_state == ST_IDLE && w_accept && w_action == ACT_READ
                    && !(w_body_ok && w_part < PART_STATIC)) begin
                r_step <= 1'b1;
            end
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;
    assign m_tuser  = r_mpart;

`include "assert_macros.svh"

    // The memory is written only by a write command or the store sweep.
    `ASSERT_SAME(a_ram_write_state, i_clk, i_rst_n, w_ram_we,
                 r_state == ST_WR || r_state == ST_STORE)
    // The iterative unit is idle whenever a new operation is started.
    `ASSERT_SAME(a_iter_free, i_clk, i_rst_n, w_req.start, !w_sts.busy)
    // Load and store sweeps never overlap a running divide or square root.
    `ASSERT_SAME(a_sweep_quiet, i_clk, i_rst_n,
                 r_state == ST_LOAD || r_state == ST_STORE, !w_sts.busy)
    // A loaded result stays offered in the next cycle unless it was taken.
    `ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, r_mvalid && !m_tready, r_mvalid)

endmodule
